### rtl/lcpd_pkg.sv
// Shared types and constants for the length-prefixed CRC packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcpd_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned LEN_ACC_W   = 24;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned FAULT_W     = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned LEN_BYTES_W = 2;

  // Default for the top-level length parameter.
  localparam int unsigned LENGTH_WIDTH_DEF = 24;

  // Register reset values.
  localparam logic [CRC_W-1:0]     CRC_POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0]     CRC_INIT_RST = 16'h0000;
  localparam logic [LEN_ACC_W-1:0] MAX_LEN_RST  = 24'd512;

  // Framing bytes.
  localparam logic [BYTE_W-1:0] START_ONE_LEN   = 8'd2;
  localparam logic [BYTE_W-1:0] START_TWO_LEN   = 8'd3;
  localparam logic [BYTE_W-1:0] START_THREE_LEN = 8'd4;
  localparam logic [BYTE_W-1:0] END_BYTE        = 8'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GOOD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FAULT_NONE      = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_BAD_START = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_ZERO_LEN  = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_TOO_LONG  = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_CRC       = 3'd4;
  localparam logic [FAULT_W-1:0] FAULT_BAD_END   = 3'd5;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_CRC_POLY = 2'd0,
    REG_CRC_INIT = 2'd1,
    REG_MAX_LEN  = 2'd2
  } reg_idx_t;

  // Configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [CRC_W-1:0]     crc_poly;
    logic [CRC_W-1:0]     crc_init;
    logic [LEN_ACC_W-1:0] max_len;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/lcpd_crc_byte.sv
// One-byte CRC-16 update, non-reflected and MSB first, with a programmable polynomial.
// Depends on lcpd_pkg.
`default_nettype none

module lcpd_crc_byte (
  input  wire logic [lcpd_pkg::CRC_W-1:0]  crc_in,
  input  wire logic [lcpd_pkg::BYTE_W-1:0] data_in,
  input  wire logic [lcpd_pkg::CRC_W-1:0]  poly,
  output logic      [lcpd_pkg::CRC_W-1:0]  crc_out
);
  import lcpd_pkg::*;

  // Eight shift steps on a 16-bit value, one per data bit.
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data_in, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### rtl/lcpd_regs.sv
// APB-style configuration registers: CRC polynomial, CRC initial value, payload limit.
// Depends on lcpd_pkg.
`default_nettype none

module lcpd_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lcpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lcpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output lcpd_pkg::cfg_t                       cfg
);
  import lcpd_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly <= CRC_POLY_RST;
      cfg_r.crc_init <= CRC_INIT_RST;
      cfg_r.max_len  <= MAX_LEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CRC_POLY: cfg_r.crc_poly <= pwdata[CRC_W-1:0];
        REG_CRC_INIT: cfg_r.crc_init <= pwdata[CRC_W-1:0];
        REG_MAX_LEN:  cfg_r.max_len  <= pwdata[LEN_ACC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRC_POLY: prdata = {{(APB_DATA_W-CRC_W){1'b0}}, cfg_r.crc_poly};
      REG_CRC_INIT: prdata = {{(APB_DATA_W-CRC_W){1'b0}}, cfg_r.crc_init};
      REG_MAX_LEN:  prdata = {{(APB_DATA_W-LEN_ACC_W){1'b0}}, cfg_r.max_len};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/length_crc_packet_deframer.sv
// Length-prefixed frame deframer with CRC-16 check.
// Each accepted byte's result word is registered and presented in the cycle after acceptance.
// One byte per cycle while out_ready is high; the output register frees on the edge it is read.
// Reset: synchronous, active low; returns to idle and restores the register defaults.
// Depends on lcpd_pkg, lcpd_regs and lcpd_crc_byte.
`default_nettype none

module length_crc_packet_deframer #(
  parameter int unsigned LENGTH_WIDTH = lcpd_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input byte channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lcpd_pkg::BYTE_W-1:0]     in_rx_byte,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [lcpd_pkg::KIND_W-1:0]     out_result_kind,
  output logic      [lcpd_pkg::BYTE_W-1:0]     out_payload_byte,
  output logic                                 out_last_payload,
  output logic      [lcpd_pkg::FAULT_W-1:0]    out_fault_code,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lcpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lcpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import lcpd_pkg::*;

  // Frame phases. The start byte is taken in idle, then length, payload, two CRC
  // bytes and the end byte follow in that order.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_END
  } phase_t;

  cfg_t cfg;

  lcpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame state.
  phase_t                  phase_r,     phase_nxt;
  logic [LEN_BYTES_W-1:0]  len_left_r,  len_left_nxt;
  logic [LEN_ACC_W-1:0]    len_acc_r,   len_acc_nxt;
  logic [LENGTH_WIDTH-1:0] remain_r,    remain_nxt;
  logic [CRC_W-1:0]        crc_r,       crc_nxt;
  logic [CRC_W-1:0]        rx_crc_r,    rx_crc_nxt;

  // Output register.
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r,  kind_nxt;
  logic [BYTE_W-1:0]  pbyte_r, pbyte_nxt;
  logic               last_r,  last_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;

  logic [CRC_W-1:0] crc_upd;
  logic             accept;
  logic             len_over;
  logic             is_last;

  // The output register holds one word; a new byte may enter whenever that word
  // is absent or is being taken on this edge.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_payload_byte = pbyte_r;
  assign out_last_payload = last_r;
  assign out_fault_code   = fault_r;

  lcpd_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_rx_byte),
    .poly    (cfg.crc_poly),
    .crc_out (crc_upd)
  );

  // A length that needs more than LENGTH_WIDTH bits is rejected like one over the limit.
  assign len_over = (len_acc_nxt >> LENGTH_WIDTH) != '0;
  assign is_last  = remain_r <= LENGTH_WIDTH'(1);

  always_comb begin
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    len_acc_nxt  = len_acc_r;
    remain_nxt   = remain_r;
    crc_nxt      = crc_r;
    rx_crc_nxt   = rx_crc_r;
    kind_nxt     = KIND_NONE;
    pbyte_nxt    = '0;
    last_nxt     = 1'b0;
    fault_nxt    = FAULT_NONE;

    unique case (phase_r)
      PH_IDLE: begin
        // The start byte also encodes how many length bytes follow.
        if (in_rx_byte == START_ONE_LEN || in_rx_byte == START_TWO_LEN ||
            in_rx_byte == START_THREE_LEN) begin
          len_left_nxt = LEN_BYTES_W'(in_rx_byte - 8'd1);
          len_acc_nxt  = '0;
          phase_nxt    = PH_LENGTH;
        end else begin
          kind_nxt  = KIND_BAD;
          fault_nxt = FAULT_BAD_START;
        end
      end
      PH_LENGTH: begin
        len_acc_nxt  = {len_acc_r[LEN_ACC_W-BYTE_W-1:0], in_rx_byte};
        len_left_nxt = len_left_r - LEN_BYTES_W'(1);
        if (len_left_nxt == '0) begin
          if (len_acc_nxt == '0) begin
            kind_nxt  = KIND_BAD;
            fault_nxt = FAULT_ZERO_LEN;
            phase_nxt = PH_IDLE;
          end else if (len_acc_nxt > cfg.max_len || len_over) begin
            kind_nxt  = KIND_BAD;
            fault_nxt = FAULT_TOO_LONG;
            phase_nxt = PH_IDLE;
          end else begin
            crc_nxt    = cfg.crc_init;
            remain_nxt = len_acc_nxt[LENGTH_WIDTH-1:0];
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        // Payload bytes pass straight out while the CRC runs over them.
        crc_nxt   = crc_upd;
        kind_nxt  = KIND_DATA;
        pbyte_nxt = in_rx_byte;
        last_nxt  = is_last;
        if (is_last) begin
          remain_nxt = '0;
          phase_nxt  = PH_CRC_HI;
        end else begin
          remain_nxt = remain_r - LENGTH_WIDTH'(1);
        end
      end
      PH_CRC_HI: begin
        rx_crc_nxt = {in_rx_byte, {BYTE_W{1'b0}}};
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rx_crc_nxt = {rx_crc_r[CRC_W-1:BYTE_W], in_rx_byte};
        phase_nxt  = PH_END;
      end
      PH_END: begin
        // A bad end byte outranks a CRC mismatch.
        if (in_rx_byte != END_BYTE) begin
          kind_nxt  = KIND_BAD;
          fault_nxt = FAULT_BAD_END;
        end else if (rx_crc_r != crc_r) begin
          kind_nxt  = KIND_BAD;
          fault_nxt = FAULT_CRC;
        end else begin
          kind_nxt = KIND_GOOD;
        end
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Frame state advances only on an accepted byte; every accepted byte loads
  // exactly one result word into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      len_left_r  <= '0;
      len_acc_r   <= '0;
      remain_r    <= '0;
      crc_r       <= '0;
      rx_crc_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        len_left_r  <= len_left_nxt;
        len_acc_r   <= len_acc_nxt;
        remain_r    <= remain_nxt;
        crc_r       <= crc_nxt;
        rx_crc_r    <= rx_crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      last_r  <= last_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

`default_nettype wire

### bench/lcpd_frame_checker.sv
`timescale 1ns / 1ps
// Result checker for the length-prefixed CRC packet deframer: tracks register writes,
// predicts one result word per accepted byte and compares it with what the block returns.
// Depends on lcpd_pkg.

module lcpd_frame_checker #(
  parameter int unsigned LENGTH_WIDTH = lcpd_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [lcpd_pkg::BYTE_W-1:0]     in_rx_byte,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [lcpd_pkg::KIND_W-1:0]     out_result_kind,
  input  wire logic [lcpd_pkg::BYTE_W-1:0]     out_payload_byte,
  input  wire logic                            out_last_payload,
  input  wire logic [lcpd_pkg::FAULT_W-1:0]    out_fault_code,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lcpd_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic                            pready,
  output int                                   mismatch_count,
  output int                                   words_pending
);

  import lcpd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LENGTH, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_END
  } deframe_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [FAULT_W-1:0] fault;
  } deframe_word_t;

  // Register copies, written as the bus writes them.
  logic [CRC_W-1:0]     poly;
  logic [CRC_W-1:0]     crc_seed;
  logic [LEN_ACC_W-1:0] max_len;

  // Parser state.
  deframe_phase_t       phase;
  logic [1:0]           len_bytes_left;
  logic [LEN_ACC_W-1:0] frame_len;
  logic [LEN_ACC_W-1:0] bytes_left;
  logic [CRC_W-1:0]     crc_run;
  logic [CRC_W-1:0]     crc_rx;

  deframe_word_t expected_words[$];
  deframe_word_t want;

  function automatic logic [CRC_W-1:0] crc_after_byte(logic [CRC_W-1:0] crc,
                                                      logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // Advances the parser by one byte and returns the word it should produce.
  function automatic deframe_word_t deframe_byte(logic [BYTE_W-1:0] b);
    deframe_word_t w;
    logic          at_last;
    w = '{kind: KIND_NONE, data: '0, last: 1'b0, fault: FAULT_NONE};
    case (phase)
      PH_IDLE: begin
        if (b == START_ONE_LEN || b == START_TWO_LEN || b == START_THREE_LEN) begin
          len_bytes_left = 2'(b - 8'd1);
          frame_len = '0;
          phase = PH_LENGTH;
        end else begin
          w.kind = KIND_BAD;
          w.fault = FAULT_BAD_START;
        end
      end
      PH_LENGTH: begin
        frame_len = {frame_len[LEN_ACC_W-9:0], b};
        len_bytes_left = len_bytes_left - 2'd1;
        if (len_bytes_left == 2'd0) begin
          if (frame_len == '0) begin
            w.kind = KIND_BAD;
            w.fault = FAULT_ZERO_LEN;
            phase = PH_IDLE;
          end else if (frame_len > max_len ||
                       (32'(frame_len) >> (LENGTH_WIDTH - 1)) > 32'd1) begin
            w.kind = KIND_BAD;
            w.fault = FAULT_TOO_LONG;
            phase = PH_IDLE;
          end else begin
            crc_run = crc_seed;
            bytes_left = frame_len;
            phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_run = crc_after_byte(crc_run, b);
        at_last = (bytes_left <= 1);
        w.kind = KIND_DATA;
        w.data = b;
        w.last = at_last;
        if (at_last) begin
          bytes_left = '0;
          phase = PH_CRC_HI;
        end else begin
          bytes_left = bytes_left - 1'b1;
        end
      end
      PH_CRC_HI: begin
        crc_rx = {b, 8'h00};
        phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_rx[7:0] = b;
        phase = PH_END;
      end
      PH_END: begin
        // A wrong end byte wins over a CRC mismatch.
        if (b != END_BYTE) begin
          w.kind = KIND_BAD;
          w.fault = FAULT_BAD_END;
        end else if (crc_rx != crc_run) begin
          w.kind = KIND_BAD;
          w.fault = FAULT_CRC;
        end else begin
          w.kind = KIND_GOOD;
        end
        phase = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
    return w;
  endfunction

  task automatic compare_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      poly = CRC_POLY_RST;
      crc_seed = CRC_INIT_RST;
      max_len = MAX_LEN_RST;
      phase = PH_IDLE;
      len_bytes_left = '0;
      frame_len = '0;
      bytes_left = '0;
      crc_run = '0;
      crc_rx = '0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CRC_POLY: poly = pwdata[CRC_W-1:0];
          REG_CRC_INIT: crc_seed = pwdata[CRC_W-1:0];
          REG_MAX_LEN:  max_len = pwdata[LEN_ACC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing outstanding, expected none, actual kind %0d",
                   $time, out_result_kind);
        end else begin
          want = expected_words.pop_front();
          compare_field("result_kind", want.kind, out_result_kind);
          compare_field("payload_byte", want.data, out_payload_byte);
          compare_field("last_payload", want.last, out_last_payload);
          compare_field("fault_code", want.fault, out_fault_code);
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(deframe_byte(in_rx_byte));
      end
    end
    words_pending = expected_words.size();
  end

endmodule

### bench/tb_length_crc_packet_deframer.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, frame stimulus, register writes and verdict.
// Depends on lcpd_pkg, lcpd_frame_checker and the length_crc_packet_deframer RTL.

module tb_length_crc_packet_deframer;

  import lcpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 250;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_END_AND_CRC} frame_flaw_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     out_result_kind;
  logic [BYTE_W-1:0]     out_payload_byte;
  logic                  out_last_payload;
  logic [FAULT_W-1:0]    out_fault_code;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int words_pending;

  // The stimulus side keeps its own copy of the registers so it can build frames
  // with a correct CRC and pick lengths on either side of the limit.
  logic [CRC_W-1:0]     cur_poly = CRC_POLY_RST;
  logic [CRC_W-1:0]     cur_init = CRC_INIT_RST;
  logic [LEN_ACC_W-1:0] cur_max = MAX_LEN_RST;

  // Bytes waiting to be offered on the input channel, in stream order.
  logic [BYTE_W-1:0] tx_fifo[$];

  int cycle_count = 0;
  int bytes_queued = 0;
  int frames_queued = 0;
  int settings_used = 1;
  int hold_trigger = 0;

  length_crc_packet_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_last_payload (out_last_payload),
    .out_fault_code   (out_fault_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  lcpd_frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_last_payload (out_last_payload),
    .out_fault_code   (out_fault_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count   (mismatch_count),
    .words_pending    (words_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d result words still outstanding",
               $time, cycle_count, words_pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: pops bytes off the queue and offers them in bursts of random length.
  // About one burst in four is followed by no gap at all, so back-to-back words
  // and idle cycles both land on every phase of the parser.
  initial begin
    int burst_left;
    int gap;
    burst_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (tx_fifo.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= tx_fifo.pop_front();
        do @(posedge clk); while (!in_ready);
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end else begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Receiver: switches between stall patterns at random intervals. When the
  // stimulus asks for it, it also holds off for a long counted stretch so the
  // output register fills and the block has to push back on its input.
  int  hold_left = 0;
  int  holds_served = 0;
  int  rx_mode = 0;
  int  mode_left = 0;
  logic next_ready;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (hold_trigger > holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      next_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (rx_mode)
        0: next_ready = 1'b1;
        1: next_ready = ($urandom_range(0, 3) != 0);
        2: next_ready = ($urandom_range(0, 3) == 0);
        default: next_ready = (cycle_count % 3 == 0);
      endcase
    end
    out_ready <= next_ready;
  end

  function automatic logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ cur_poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic int len_bytes_for(int unsigned len);
    return (len < 256) ? 1 : (len < 65536) ? 2 : 3;
  endfunction

  task automatic push_byte(logic [BYTE_W-1:0] b);
    tx_fifo.push_back(b);
    bytes_queued++;
  endtask

  // Start byte and big-endian length field; on its own this is the whole frame
  // for a zero or over-limit length, since the block drops back to idle there.
  task automatic queue_header(int unsigned len, int len_bytes);
    push_byte(START_ONE_LEN + 8'(len_bytes - 1));
    for (int i = len_bytes - 1; i >= 0; i--) begin
      push_byte(8'(len >> (8 * i)));
    end
    frames_queued++;
  endtask

  // Full frame. A negative fill means random payload content. The CRC is flipped
  // in one random bit and/or the end byte replaced to build broken frames.
  task automatic queue_frame(int unsigned len, int len_bytes, frame_flaw_t flaw, int fill);
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    queue_header(len, len_bytes);
    crc = cur_init;
    for (int unsigned i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      crc = crc_next(crc, b);
      push_byte(b);
    end
    if (flaw == FLAW_CRC || flaw == FLAW_END_AND_CRC) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    push_byte(crc[15:8]);
    push_byte(crc[7:0]);
    if (flaw == FLAW_END || flaw == FLAW_END_AND_CRC) begin
      do b = 8'($urandom_range(0, 255)); while (b == END_BYTE);
      push_byte(b);
    end else begin
      push_byte(END_BYTE);
    end
  endtask

  // A byte that cannot start a frame; the block reports it and stays idle.
  task automatic queue_bad_start();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == START_ONE_LEN || b == START_TWO_LEN || b == START_THREE_LEN);
    push_byte(b);
  endtask

  // Mostly well-formed frames with random content and length field size, mixed
  // with every kind of broken frame and some stray bytes between frames.
  task automatic queue_random(int target);
    int          first;
    int          r;
    int unsigned len;
    int unsigned room;
    int unsigned cap;
    frame_flaw_t flaw;
    first = bytes_queued;
    while (bytes_queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 3)) queue_bad_start();
      end else if (r < 10) begin
        queue_header(0, $urandom_range(1, 3));
      end else if (r < 16 && cur_max != 24'hFFFFFF) begin
        room = 24'hFFFFFF - cur_max;
        if ($urandom_range(0, 3) == 0) begin
          len = 24'hFFFFFF;
        end else begin
          len = cur_max + 1 + $urandom_range(0, (room - 1 < 1000) ? room - 1 : 1000);
        end
        queue_header(len, $urandom_range(len_bytes_for(len), 3));
      end else begin
        // Mostly short payloads; now and then a long one.
        cap = ($urandom_range(0, 19) == 0) ? 300 : 16;
        if (cap > cur_max) cap = cur_max;
        len = $urandom_range(1, cap);
        flaw = (r < 24) ? FLAW_CRC : (r < 30) ? FLAW_END :
               (r < 33) ? FLAW_END_AND_CRC : FLAW_NONE;
        queue_frame(len, $urandom_range(len_bytes_for(len), 3), flaw, -1);
      end
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CRC_POLY: cur_poly = value[CRC_W-1:0];
      REG_CRC_INIT: cur_init = value[CRC_W-1:0];
      default:      cur_max = value[LEN_ACC_W-1:0];
    endcase
  endtask

  // Waits for the stream to drain and every word to come back before the registers change.
  task automatic drain();
    while (tx_fifo.size() != 0 || in_valid || words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [CRC_W-1:0] poly, logic [CRC_W-1:0] init,
                            logic [LEN_ACC_W-1:0] max_len);
    drain();
    write_reg(REG_CRC_POLY, 32'(poly));
    write_reg(REG_CRC_INIT, 32'(init));
    write_reg(REG_MAX_LEN, 32'(max_len));
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames on the reset register values: one, two and three length
    // bytes, all-zero and all-one payloads, stray bytes in idle, zero length,
    // lengths past the limit and the largest that three bytes hold, a CRC error, a bad end byte,
    // and a bad end byte on a frame whose CRC is also wrong.
    queue_frame(1, 1, FLAW_NONE, 8'h00);
    queue_frame(3, 2, FLAW_NONE, 8'hFF);
    queue_frame(2, 3, FLAW_NONE, -1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'h05);
    queue_header(0, 1);
    queue_header(513, 2);
    queue_header(24'hFFFFFF, 3);
    queue_frame(2, 1, FLAW_CRC, -1);
    queue_frame(2, 1, FLAW_END, -1);
    queue_frame(1, 1, FLAW_END_AND_CRC, -1);

    // Random traffic on the defaults. With the queue well stocked, the receiver
    // is asked for its long hold-off while the sender keeps offering words.
    queue_random(100);
    hold_trigger <= hold_trigger + 1;

    // Extreme registers: all-ones polynomial and seed, a limit of one.
    set_config(16'hFFFF, 16'hFFFF, 24'd1);
    queue_frame(1, 3, FLAW_NONE, -1);
    queue_header(2, 1);
    queue_random(40);

    // Zero polynomial and seed, the largest limit.
    set_config(16'h0000, 16'h0000, 24'hFFFFFF);
    queue_frame(5, 3, FLAW_NONE, -1);
    queue_header(0, 3);
    queue_random(40);

    // A different polynomial, a random seed and a small limit, hit exactly and
    // missed by one.
    set_config(16'h8005, 16'($urandom_range(0, 65535)), 24'($urandom_range(20, 64)));
    queue_frame(cur_max, 1, FLAW_NONE, -1);
    queue_header(cur_max + 1, 2);
    queue_random(50);

    drain();
    $display("Sent %0d bytes in %0d frames and stray bytes under %0d register settings,",
             bytes_queued, frames_queued, settings_used);
    $display("covering good frames and every fault kind, in %0d cycles.", cycle_count);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d result words missing", mismatch_count, words_pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
